// File: hw/rtl/mrpp_pkg.sv
// Shared types and constants for the MQTT receive packet parser.
// Used by the parser front end, the result queue, the output stage and the top level.
`default_nettype none

package mrpp_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PACKET  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM_MODE = 1'd1;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers.
	localparam logic [15:0] MAX_PACKET_RESET = 16'd256;

	// Default depth of the queue between the parser and the output stage.
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	// MQTT packet type for PUBLISH.
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	// Saturation value of the packet position counter.
	localparam logic [28:0] POS_MAX = 29'h1FFF_FFFF;

	// Byte classes.
	localparam logic [2:0] CLS_HEADER  = 3'd0;
	localparam logic [2:0] CLS_LENGTH  = 3'd1;
	localparam logic [2:0] CLS_TLEN    = 3'd2;
	localparam logic [2:0] CLS_TOPIC   = 3'd3;
	localparam logic [2:0] CLS_MSGID   = 3'd4;
	localparam logic [2:0] CLS_PAYLOAD = 3'd5;
	localparam logic [2:0] CLS_OTHER   = 3'd6;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_TLEN_HI = 3'd2,
		PH_TLEN_LO = 3'd3,
		PH_BODY    = 3'd4
	} phase_t;

	// One classified byte as it leaves the parser; stored and oversize are
	// settled later against the position.
	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_byte;
		logic [3:0]  packet_type;
		logic [1:0]  qos_level;
		logic [27:0] remaining_length;
		logic [2:0]  length_bytes;
		logic [15:0] topic_length;
		logic [15:0] message_id;
		logic [28:0] position;
		logic        last;
		logic        malformed;
	} parse_res_t;

	// Status that the queue shows the output stage.
	typedef struct packed {
		logic valid;
	} queue_hs_t;

endpackage

`default_nettype wire

// File: hw/rtl/mrpp_front.sv
// Parser front end: tracks the packet phase and classifies each received byte.
// Depends on mrpp_pkg.
`default_nettype none

module mrpp_front import mrpp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	output parse_res_t      res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  header_q, hdr;
	logic [27:0] rt_q, rt_cur, rt_d, rt_add;
	logic [2:0]  cnt_q, cnt_cur, cnt_d;
	logic [27:0] body_q, body_cur, body_d;
	logic [15:0] tlen_q, tlen_cur, tlen_d;
	logic [15:0] tleft_q, tleft_cur, tleft_d;
	logic [15:0] mid_q, mid_cur, mid_d;
	logic [1:0]  mleft_q, mleft_cur, mleft_d;
	logic [28:0] pos_q, pos_cur, pos_d;
	logic        is_pub;
	logic [1:0]  qos;
	logic [2:0]  cls;
	logic        last, malformed;

	// Current view of the state; a header byte starts from a clean packet.
	always_comb begin
		hdr       = header_q;
		rt_cur    = rt_q;
		cnt_cur   = cnt_q;
		body_cur  = body_q;
		tlen_cur  = tlen_q;
		tleft_cur = tleft_q;
		mid_cur   = mid_q;
		mleft_cur = mleft_q;
		pos_cur   = pos_q;
		if (phase_q == PH_HEADER) begin
			hdr       = rx_byte;
			rt_cur    = '0;
			cnt_cur   = '0;
			body_cur  = '0;
			tlen_cur  = '0;
			tleft_cur = '0;
			mid_cur   = '0;
			mleft_cur = '0;
			pos_cur   = '0;
		end
	end

	assign is_pub = (hdr[7:4] == TYPE_PUBLISH);
	assign qos    = is_pub ? hdr[2:1] : 2'd0;

	// Seven-bit length group placed by its index.
	always_comb begin
		case (cnt_cur[1:0])
			2'd0:    rt_add = {21'd0, rx_byte[6:0]};
			2'd1:    rt_add = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    rt_add = {7'd0, rx_byte[6:0], 14'd0};
			default: rt_add = {rx_byte[6:0], 21'd0};
		endcase
	end

	// Byte classification and datapath updates.
	always_comb begin
		rt_d      = rt_cur;
		cnt_d     = cnt_cur;
		body_d    = body_cur;
		tlen_d    = tlen_cur;
		tleft_d   = tleft_cur;
		mid_d     = mid_cur;
		mleft_d   = mleft_cur;
		cls       = CLS_OTHER;
		last      = 1'b0;
		malformed = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				cls = CLS_HEADER;
			end
			PH_LENGTH: begin
				cls   = CLS_LENGTH;
				rt_d  = rt_cur + rt_add;
				cnt_d = cnt_cur + 3'd1;
				if (rx_byte[7]) begin
					if (cnt_d >= 3'd4) begin
						malformed = 1'b1;
						last      = 1'b1;
					end
				end else if (!is_pub) begin
					if (rt_d == '0) begin
						last = 1'b1;
					end else begin
						body_d = rt_d;
					end
				end
			end
			PH_TLEN_HI: begin
				cls    = CLS_TLEN;
				tlen_d = {rx_byte, 8'd0};
			end
			PH_TLEN_LO: begin
				cls     = CLS_TLEN;
				tlen_d  = tlen_cur | {8'd0, rx_byte};
				tleft_d = tlen_d;
				mleft_d = (qos != 2'd0) ? 2'd2 : 2'd0;
				body_d  = (rt_cur >= 28'd2) ? rt_cur - 28'd2 : 28'd0;
				last    = (body_d == '0);
			end
			default: begin
				if (!is_pub) begin
					cls = CLS_OTHER;
				end else if (tleft_cur != '0) begin
					cls     = CLS_TOPIC;
					tleft_d = tleft_cur - 16'd1;
				end else if (mleft_cur != '0) begin
					cls     = CLS_MSGID;
					mid_d   = {mid_cur[7:0], rx_byte};
					mleft_d = mleft_cur - 2'd1;
				end else begin
					cls = CLS_PAYLOAD;
				end
				if (body_cur != '0) begin
					body_d = body_cur - 28'd1;
				end
				last = (body_d == '0);
			end
		endcase
		pos_d = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 29'd1;
	end

	// Next phase.
	always_comb begin
		case (phase_q)
			PH_HEADER: phase_d = PH_LENGTH;
			PH_LENGTH: begin
				if (last) begin
					phase_d = PH_HEADER;
				end else if (rx_byte[7]) begin
					phase_d = PH_LENGTH;
				end else if (is_pub) begin
					phase_d = PH_TLEN_HI;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_TLEN_HI: phase_d = PH_TLEN_LO;
			PH_TLEN_LO: phase_d = last ? PH_HEADER : PH_BODY;
			PH_BODY:    phase_d = last ? PH_HEADER : PH_BODY;
			default:    phase_d = PH_HEADER;
		endcase
	end

	// Result of the byte in hand.
	always_comb begin
		res.byte_class       = cls;
		res.data_byte        = rx_byte;
		res.packet_type      = hdr[7:4];
		res.qos_level        = qos;
		res.remaining_length = rt_d;
		res.length_bytes     = cnt_d;
		res.topic_length     = tlen_d;
		res.message_id       = mid_d;
		res.position         = pos_cur;
		res.last             = last;
		res.malformed        = malformed;
	end

	// Parser state, updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= '0;
			rt_q     <= '0;
			cnt_q    <= '0;
			body_q   <= '0;
			tlen_q   <= '0;
			tleft_q  <= '0;
			mid_q    <= '0;
			mleft_q  <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			header_q <= hdr;
			rt_q     <= rt_d;
			cnt_q    <= cnt_d;
			body_q   <= body_d;
			tlen_q   <= tlen_d;
			tleft_q  <= tleft_d;
			mid_q    <= mid_d;
			mleft_q  <= mleft_d;
			pos_q    <= pos_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mrpp_queue.sv
// Short queue of classified bytes between the parser and the output stage.
// Depends on mrpp_pkg.
`default_nettype none

module mrpp_queue import mrpp_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  parse_res_t      wr_data,
	output logic            full,
	input  wire logic       rd_en,
	output queue_hs_t       hs_valid,
	output parse_res_t      rd_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	parse_res_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full           = (count_q == CNT_FULL);
	assign hs_valid.valid = (count_q != '0);
	assign rd_data        = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_ONE;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mrpp_back.sv
// Output stage: settles stored and oversize against the configuration and holds the result.
// Depends on mrpp_pkg.
`default_nettype none

module mrpp_back import mrpp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  queue_hs_t        q_hs,
	input  parse_res_t       q_data,
	output logic             q_take,
	input  wire logic [15:0] max_packet,
	input  wire logic        stream_mode,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       byte_class,
	output logic [7:0]       data_byte,
	output logic [3:0]       packet_type,
	output logic [1:0]       qos_level,
	output logic [27:0]      remaining_length,
	output logic [2:0]       length_bytes,
	output logic [15:0]      topic_length,
	output logic [15:0]      message_id,
	output logic             stored,
	output logic             last,
	output logic             malformed,
	output logic             oversize
);

	logic        valid_q;
	parse_res_t  res_q;
	logic        stored_q, oversize_q;
	logic [28:0] max_ext;
	logic        below_max;

	// Load a new beat when the output register is free or being emptied.
	assign q_take    = q_hs.valid && (!valid_q || pop);
	assign max_ext   = {13'd0, max_packet};
	assign below_max = (q_data.position < max_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (q_take) begin
			res_q      <= q_data;
			stored_q   <= below_max;
			oversize_q <= q_data.last && !q_data.malformed && !stream_mode && !below_max;
		end
	end

	assign empty            = !valid_q;
	assign byte_class       = res_q.byte_class;
	assign data_byte        = res_q.data_byte;
	assign packet_type      = res_q.packet_type;
	assign qos_level        = res_q.qos_level;
	assign remaining_length = res_q.remaining_length;
	assign length_bytes     = res_q.length_bytes;
	assign topic_length     = res_q.topic_length;
	assign message_id       = res_q.message_id;
	assign stored           = stored_q;
	assign last             = res_q.last;
	assign malformed        = res_q.malformed;
	assign oversize         = oversize_q;

endmodule

`default_nettype wire

// File: hw/rtl/mqtt_receive_packet_parser.sv
// MQTT receive packet parser. Accepts one received byte per cycle while full is low and returns
// one result beat per byte, in order: its class within the packet, the decoded header and length
// fields, the PUBLISH topic length and message id, and the stored, last, malformed and oversize
// flags. The parser front end updates its phase in the cycle a byte is accepted, so a new byte
// can be pushed every cycle while full is low; a result passes through the result queue
// (QUEUE_DEPTH beats) and the output register before it reaches the output ports. full is high
// while the queue holds QUEUE_DEPTH beats, and it fills only while the output beat waits unpopped.
// Configuration writes take effect at the next edge and should be made while no beat is queued.
`default_nettype none

module mqtt_receive_packet_parser import mrpp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             rx_byte,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [2:0]                  byte_class,
	output logic [7:0]                  data_byte,
	output logic [3:0]                  packet_type,
	output logic [1:0]                  qos_level,
	output logic [27:0]                 remaining_length,
	output logic [2:0]                  length_bytes,
	output logic [15:0]                 topic_length,
	output logic [15:0]                 message_id,
	output logic                        stored,
	output logic                        last,
	output logic                        malformed,
	output logic                        oversize
);

	logic [15:0] max_packet_q;
	logic        stream_mode_q;
	logic        in_beat;
	parse_res_t  front_res, queue_res;
	queue_hs_t   queue_hs;
	logic        queue_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packet_q  <= MAX_PACKET_RESET;
			stream_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PACKET:  max_packet_q  <= cfg_wdata;
				REG_STREAM_MODE: stream_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign in_beat = push && !full;

	// Parser front end.
	mrpp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_beat),
		.rx_byte (rx_byte),
		.res     (front_res)
	);

	// Queue between parser and output stage.
	mrpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_beat),
		.wr_data  (front_res),
		.full     (full),
		.rd_en    (queue_take),
		.hs_valid (queue_hs),
		.rd_data  (queue_res)
	);

	// Output stage.
	mrpp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_hs             (queue_hs),
		.q_data           (queue_res),
		.q_take           (queue_take),
		.max_packet       (max_packet_q),
		.stream_mode      (stream_mode_q),
		.empty            (empty),
		.pop              (pop),
		.byte_class       (byte_class),
		.data_byte        (data_byte),
		.packet_type      (packet_type),
		.qos_level        (qos_level),
		.remaining_length (remaining_length),
		.length_bytes     (length_bytes),
		.topic_length     (topic_length),
		.message_id       (message_id),
		.stored           (stored),
		.last             (last),
		.malformed        (malformed),
		.oversize         (oversize)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mrpp_checker.sv
// Port-level checks for the MQTT receive packet parser, attached by a bind statement.
// Depends on mrpp_pkg and the top level mqtt_receive_packet_parser.
`default_nettype none

module mrpp_checker import mrpp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [2:0]  byte_class,
	input wire logic [7:0]  data_byte,
	input wire logic [27:0] remaining_length,
	input wire logic [2:0]  length_bytes,
	input wire logic        last,
	input wire logic        malformed,
	input wire logic        oversize
);

	// A waiting beat that is not popped stays on the ports.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(byte_class)))
		else $error("result beat changed while waiting");

	// Oversize is only reported on the final byte of a packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && oversize) |-> (last && !malformed))
		else $error("oversize outside packet end");

	// A malformed length ends the packet on its fourth length byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && malformed) |-> (last && byte_class == CLS_LENGTH && length_bytes == 3'd4))
		else $error("malformed flag on wrong byte");

	// A header byte opens a clean packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && byte_class == CLS_HEADER) |->
			(!last && remaining_length == '0 && length_bytes == '0))
		else $error("header beat carries stale packet state");

endmodule

bind mqtt_receive_packet_parser mrpp_checker u_mrpp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.byte_class       (byte_class),
	.data_byte        (data_byte),
	.remaining_length (remaining_length),
	.length_bytes     (length_bytes),
	.last             (last),
	.malformed        (malformed),
	.oversize         (oversize)
);

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for mqtt_receive_packet_parser: byte stream in, one classified beat out.
// Holds its own model of the parser in a scoreboard class; depends on mrpp_pkg and the RTL only.

module tb_top;
	import mrpp_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_ITEMS    = 150;

	// One result beat as seen on the output ports.
	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_byte;
		logic [3:0]  packet_type;
		logic [1:0]  qos_level;
		logic [27:0] remaining_length;
		logic [2:0]  length_bytes;
		logic [15:0] topic_length;
		logic [15:0] message_id;
		logic        stored;
		logic        last;
		logic        malformed;
		logic        oversize;
	} beat_t;

	// Tracks the packet framing of the accepted bytes and the beats still owed.
	class parser_scoreboard;
		logic [15:0] max_pkt;
		logic        stream;
		phase_t      phase;
		logic [7:0]  hdr;
		logic [27:0] rem;
		logic [2:0]  nlen;
		logic [27:0] body_left;
		logic [15:0] tlen;
		logic [15:0] topic_left;
		logic [15:0] msg_id;
		logic [1:0]  msg_id_left;
		logic [28:0] position;
		int unsigned errors;
		beat_t       expected_beats[$];

		function new();
			max_pkt = MAX_PACKET_RESET;
			stream = 1'b0;
			phase = PH_HEADER;
			hdr = '0;
			rem = '0;
			nlen = '0;
			body_left = '0;
			tlen = '0;
			topic_left = '0;
			msg_id = '0;
			msg_id_left = '0;
			position = '0;
			errors = 0;
		endfunction

		function logic is_publish();
			return hdr[7:4] == TYPE_PUBLISH;
		endfunction

		function logic [1:0] qos();
			return is_publish() ? hdr[2:1] : 2'd0;
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		// Advance the framing state by one accepted byte and queue the beat it owes.
		function void take_byte(logic [7:0] b);
			beat_t       e;
			logic [28:0] pos;
			logic [2:0]  cls;
			logic        fin;
			logic        bad;
			logic        big;
			int unsigned pos_next;

			if (phase == PH_HEADER) begin
				hdr = b;
				rem = '0;
				nlen = '0;
				body_left = '0;
				tlen = '0;
				topic_left = '0;
				msg_id = '0;
				msg_id_left = '0;
				position = '0;
			end
			pos = position;
			cls = CLS_OTHER;
			fin = 1'b0;
			bad = 1'b0;
			big = 1'b0;

			case (phase)
				PH_HEADER: begin
					cls = CLS_HEADER;
					phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					// Seven bits per length byte, least significant group first.
					cls = CLS_LENGTH;
					rem = rem + (28'(b[6:0]) << (7 * nlen[1:0]));
					nlen = nlen + 3'd1;
					if (b[7]) begin
						if (nlen >= 3'd4) begin
							bad = 1'b1;
							fin = 1'b1;
						end
					end else if (is_publish()) begin
						phase = PH_TLEN_HI;
					end else if (rem == 0) begin
						fin = 1'b1;
					end else begin
						body_left = rem;
						phase = PH_BODY;
					end
				end
				PH_TLEN_HI: begin
					cls = CLS_TLEN;
					tlen = {b, 8'h00};
					phase = PH_TLEN_LO;
				end
				PH_TLEN_LO: begin
					// Both topic length bytes are always taken, even for a short packet.
					cls = CLS_TLEN;
					tlen = tlen | {8'h00, b};
					topic_left = tlen;
					msg_id_left = (qos() != 2'd0) ? 2'd2 : 2'd0;
					body_left = (rem >= 28'd2) ? rem - 28'd2 : 28'd0;
					if (body_left == 0)
						fin = 1'b1;
					else
						phase = PH_BODY;
				end
				default: begin
					if (!is_publish()) begin
						cls = CLS_OTHER;
					end else if (topic_left != 0) begin
						cls = CLS_TOPIC;
						topic_left = topic_left - 16'd1;
					end else if (msg_id_left != 0) begin
						cls = CLS_MSGID;
						msg_id = {msg_id[7:0], b};
						msg_id_left = msg_id_left - 2'd1;
					end else begin
						cls = CLS_PAYLOAD;
					end
					if (body_left != 0)
						body_left = body_left - 28'd1;
					if (body_left == 0)
						fin = 1'b1;
				end
			endcase

			if (fin) begin
				pos_next = 32'(pos) + 1;
				if (!bad && !stream && pos_next > 32'(max_pkt))
					big = 1'b1;
				phase = PH_HEADER;
			end
			if (position != POS_MAX)
				position = position + 29'd1;

			e.byte_class = cls;
			e.data_byte = b;
			e.packet_type = hdr[7:4];
			e.qos_level = qos();
			e.remaining_length = rem;
			e.length_bytes = nlen;
			e.topic_length = tlen;
			e.message_id = msg_id;
			e.stored = (32'(pos) < 32'(max_pkt));
			e.last = fin;
			e.malformed = bad;
			e.oversize = big;
			expected_beats.push_back(e);
		endfunction

		function void compare(string name, logic [27:0] want, logic [27:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		endfunction

		// Compare one accepted result beat against the oldest one owed.
		function void check_beat(beat_t got);
			beat_t want;

			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing owed, expected none, actual 0x%0h",
					$time, got);
				return;
			end
			want = expected_beats.pop_front();
			compare("byte_class", want.byte_class, got.byte_class);
			compare("data_byte", want.data_byte, got.data_byte);
			compare("packet_type", want.packet_type, got.packet_type);
			compare("qos_level", want.qos_level, got.qos_level);
			compare("remaining_length", want.remaining_length, got.remaining_length);
			compare("length_bytes", want.length_bytes, got.length_bytes);
			compare("topic_length", want.topic_length, got.topic_length);
			compare("message_id", want.message_id, got.message_id);
			compare("stored", want.stored, got.stored);
			compare("last", want.last, got.last);
			compare("malformed", want.malformed, got.malformed);
			compare("oversize", want.oversize, got.oversize);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   push;
	logic                   full;
	logic [7:0]             rx_byte;
	logic                   empty;
	logic                   pop;
	logic [2:0]             byte_class;
	logic [7:0]             data_byte;
	logic [3:0]             packet_type;
	logic [1:0]             qos_level;
	logic [27:0]            remaining_length;
	logic [2:0]             length_bytes;
	logic [15:0]            topic_length;
	logic [15:0]            message_id;
	logic                   stored;
	logic                   last;
	logic                   malformed;
	logic                   oversize;

	parser_scoreboard board;
	logic [7:0]       pkt_bytes[$];
	logic             idle_on;
	int unsigned      items_sent;
	int unsigned      quiet_cycles;
	int unsigned      stall_left;

	mqtt_receive_packet_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.byte_class(byte_class),
		.data_byte(data_byte),
		.packet_type(packet_type),
		.qos_level(qos_level),
		.remaining_length(remaining_length),
		.length_bytes(length_bytes),
		.topic_length(topic_length),
		.message_id(message_id),
		.stored(stored),
		.last(last),
		.malformed(malformed),
		.oversize(oversize)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one byte, with an occasional gap beforehand, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		board.take_byte(b);
		items_sent++;
	endtask

	// Stop sending and wait until every owed beat has come back.
	task automatic drain();
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Remaining length in k groups; extra groups pad the encoding with zeros.
	function automatic void append_length(input int unsigned v, input int unsigned k);
		logic [7:0] g;

		for (int i = 0; i < k; i++) begin
			g = 8'((v >> (7 * i)) & 127);
			g[7] = (i < k - 1);
			pkt_bytes.push_back(g);
		end
	endfunction

	// One packet: mostly well formed with random content, some malformed or noise.
	task automatic random_packet();
		int unsigned kind;
		int unsigned rem;
		int unsigned tl;
		int unsigned pl;
		int unsigned k;
		logic [7:0]  hdr;

		pkt_bytes.delete();
		kind = $urandom_range(0, 99);
		hdr = 8'($urandom);
		if (kind < 40) begin
			hdr[7:4] = TYPE_PUBLISH;
			tl = $urandom_range(0, 6);
			pl = $urandom_range(0, 10);
			rem = 2 + tl + ((hdr[2:1] != 2'd0) ? 2 : 0) + pl;
			pkt_bytes.push_back(hdr);
			append_length(rem, $urandom_range(1, 4));
			pkt_bytes.push_back(8'(tl >> 8));
			pkt_bytes.push_back(8'(tl));
			repeat (rem - 2) pkt_bytes.push_back(8'($urandom));
		end else if (kind < 65) begin
			while (hdr[7:4] == TYPE_PUBLISH) hdr = 8'($urandom);
			rem = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 400) : $urandom_range(0, 12);
			k = $urandom_range((rem < 128) ? 1 : 2, 4);
			pkt_bytes.push_back(hdr);
			append_length(rem, k);
			repeat (rem) pkt_bytes.push_back(8'($urandom));
		end else if (kind < 75) begin
			// Four length bytes, all with the continuation bit.
			pkt_bytes.push_back(hdr);
			repeat (4) pkt_bytes.push_back(8'($urandom) | 8'h80);
		end else if (kind < 90) begin
			// PUBLISH whose topic and message id need not fit the body.
			hdr[7:4] = TYPE_PUBLISH;
			pkt_bytes.push_back(hdr);
			append_length($urandom_range(0, 8), 1);
			pkt_bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
			pkt_bytes.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 2)) pkt_bytes.push_back(8'($urandom));
		end
		foreach (pkt_bytes[i]) send_byte(pkt_bytes[i]);
		// Close whatever packet is still open.
		while (board.phase != PH_HEADER)
			send_byte((board.phase == PH_LENGTH) ? 8'h00 : 8'($urandom));
	endtask

	// Result side: take beats, stalling in random bursts while idling is on.
	initial begin
		beat_t got;

		pop <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {byte_class, data_byte, packet_type, qos_level, remaining_length,
					length_bytes, topic_length, message_id, stored, last, malformed, oversize};
				board.check_beat(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if ((push && !full) || (pop && !empty))
					quiet_cycles = 0;
				else
					quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		logic [7:0] directed[] = '{
			// Short PUBLISH, QoS 0, remaining length zero.
			8'h30, 8'h00, 8'h00, 8'h00,
			// Non-PUBLISH packet with one other-body byte.
			8'h20, 8'h01, 8'h00,
			// Malformed length: fourth length byte still continues.
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			// PUBLISH at QoS 3 with topic, message id and payload.
			8'h36, 8'h07, 8'h00, 8'h02, 8'h61, 8'h62, 8'h12, 8'h34, 8'hFF,
			// PUBLISH at QoS 1 whose body ends inside the topic.
			8'h32, 8'h03, 8'h00, 8'h05, 8'h00
		};
		int unsigned target;
		logic [15:0] mp;
		logic        sm;

		board = new();
		idle_on = 1'b1;
		items_sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAX_PACKET;
		cfg_wdata <= '0;
		push <= 1'b0;
		rx_byte <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_byte(directed[i]);

		// Random phases, each under its own register setting.
		target = items_sent;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin mp = 16'd2; sm = 1'b0; end
				1: begin mp = 16'hFFFF; sm = 1'b1; end
				2: begin mp = 16'($urandom_range(3, 30)); sm = 1'b0; end
				3: begin mp = 16'($urandom_range(2, 40)); sm = 1'b1; end
				4: begin mp = 16'hFFFF; sm = 1'b0; end
				default: begin mp = 16'($urandom_range(2, 24)); sm = 1'b0; end
			endcase
			write_reg(REG_MAX_PACKET, mp);
			write_reg(REG_STREAM_MODE, CFG_DATA_W'(sm));
			board.max_pkt = mp;
			board.stream = sm;
			// One phase without idling mid-run, and none in the final phase.
			idle_on = (ph != 2) && (ph != 5);
			target += PHASE_ITEMS;
			while (items_sent < target) begin
				random_packet();
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
